>>> design/assert_macros.svh
// Assertion helpers shared by the tilt block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high
`define TILT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, live through reset
`define TILT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tilt_pkg.sv
package tilt_pkg;

   localparam int WFRAC = 40;
   localparam int ITERS = 48;
   localparam int RAD_SHIFT = 56;

   typedef logic [63:0] step_tab_type [ITERS];

   function automatic logic [127:0] udivmod(logic [63:0] n, logic [63:0] d);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return {r[63:0], q};
   endfunction

   function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
      logic [127:0] qr;
      qr = udivmod(n, d);
      return qr[63:0];
   endfunction

   function automatic step_tab_type build_steps();
      longint unsigned one;
      longint unsigned pi;
      longint unsigned p;
      longint unsigned sum;
      longint unsigned m;
      longint unsigned t;
      longint unsigned s5;
      longint unsigned s239;
      longint unsigned num;
      longint unsigned q;
      longint unsigned r;
      logic [127:0]    qr;
      int unsigned     sh;
      step_tab_type    tab;
      one = 64'd1 << RAD_SHIFT;
      p = udiv(one, 64'd5);
      sum = 0;
      m = 0;
      while (p != 0) begin
         t = udiv(p, 2 * m + 1);
         if (m[0]) sum = sum - t;
         else sum = sum + t;
         p = udiv(p, 64'd25);
         m = m + 1;
      end
      s5 = sum;
      p = udiv(one, 64'd239);
      sum = 0;
      m = 0;
      while (p != 0) begin
         t = udiv(p, 2 * m + 1);
         if (m[0]) sum = sum - t;
         else sum = sum + t;
         p = udiv(p, 64'd57121);
         m = m + 1;
      end
      s239 = sum;
      pi = 64'd16 * s5 - 64'd4 * s239;
      tab[0] = 64'd45 << WFRAC;
      for (int i = 1; i < ITERS; i++) begin
         p = one >> i;
         sh = 2 * i;
         sum = 0;
         m = 0;
         while (p != 0) begin
            t = udiv(p, 2 * m + 1);
            if (m[0]) sum = sum - t;
            else sum = sum + t;
            p = (sh < 64) ? (p >> sh) : 64'd0;
            m = m + 1;
         end
         num = sum * 64'd180;
         qr = udivmod(num, pi);
         q = qr[63:0];
         r = qr[127:64];
         for (int k = 0; k < WFRAC; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= pi) begin
               r = r - pi;
               q = q | 64'd1;
            end
         end
         tab[i] = q;
      end
      return tab;
   endfunction

   localparam step_tab_type STEP_DEG = build_steps();

   typedef struct packed {
      logic neg;
      logic zero_num;
      logic zero_den;
   } tilt_flags_type;

endpackage

>>> design/accel_tilt_angles_top.sv
// channel | dir | tdata, lowest bits first            | tuser/tlast
// req_    | in  | accel_x, accel_y, accel_z            | none
// rsp_    | out | angle_x, angle_y, angle_z, zero pad  | none
// One sample enters per cycle while no held result stalls the pipeline; each result
// passes through abs, squares, one square-root bit per stage, 48 CORDIC
// stages and a rounding stage.
// Reset clears the valid bits only; the datapath registers are not reset.
// A held result stalls every stage together; nothing is lost or repeated.
module accel_tilt_angles_top import tilt_pkg::*; #(
   parameter int SAMPLE_BITS = 8,
   parameter int ANGLE_FRAC_BITS = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // accel_x, accel_y, accel_z
   input  logic [(((3*SAMPLE_BITS+7)>>3)<<3)-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // angle_x, angle_y, angle_z
   output logic [(((3*(8+ANGLE_FRAC_BITS)+7)>>3)<<3)-1:0] rsp_tdata
);

   `include "assert_macros.svh"

   localparam int SB = SAMPLE_BITS;
   localparam int AB = 8 + ANGLE_FRAC_BITS;
   localparam int SW = 2 * SB;
   localparam int DEPTH = 2 + SB + WFRAC + ITERS + 1;
   localparam int RSP_W = ((3 * AB + 7) >> 3) << 3;
   localparam logic signed [AB-1:0] LIM_S = AB'(90 << ANGLE_FRAC_BITS);

   logic              pipe_en;
   logic [DEPTH-1:0]  vld_ff;

   logic signed [SB-1:0] samp [3];
   logic [SB-1:0]     abs_ff [3];
   logic              neg_ff [3];
   logic [SB-1:0]     mag2_ff [3];
   logic              neg2_ff [3];
   logic [SW-1:0]     sumsq_ff [3];
   logic [SW-1:0]     sqr [3];
   logic [AB-1:0]     angle [3];

   assign pipe_en    = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_tvalid};
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_axis
      assign samp[c] = signed'(req_tdata[c*SB +: SB]);
      assign sqr[c]  = SW'(abs_ff[c]) * SW'(abs_ff[c]);
      always_ff @(posedge clock) begin
         if (pipe_en) begin
            abs_ff[c]  <= samp[c][SB-1] ? SB'(-samp[c]) : samp[c];
            neg_ff[c]  <= samp[c][SB-1];
            mag2_ff[c] <= abs_ff[c];
            neg2_ff[c] <= neg_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sumsq_ff[0] <= sqr[1] + sqr[2];
         sumsq_ff[1] <= sqr[0] + sqr[2];
         sumsq_ff[2] <= sqr[0] + sqr[1];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      tilt_lane #(
         .SAMPLE_BITS     (SAMPLE_BITS),
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
         .NUM_IS_ROOT     (c == 2)
      ) u_lane (
         .clock     (clock),
         .enable    (pipe_en),
         .neg_in    (neg2_ff[c]),
         .mag_in    (mag2_ff[c]),
         .sumsq_in  (sumsq_ff[c]),
         .angle_out (angle[c])
      );
   end

   assign rsp_tdata = RSP_W'({angle[2], angle[1], angle[0]});

   logic signed [AB-1:0] ang_x;
   logic signed [AB-1:0] ang_z;
   assign ang_x = signed'(angle[0]);
   assign ang_z = signed'(angle[2]);

   `TILT_ASSERT(a_range_x, clock, reset, rsp_tvalid |-> ang_x >= -LIM_S && ang_x <= LIM_S, "angle_x range")
   `TILT_ASSERT(a_range_z, clock, reset, rsp_tvalid |-> ang_z >= -LIM_S && ang_z <= LIM_S, "angle_z range")
   `TILT_ASSERT(a_stall_hold, clock, reset, !pipe_en |=> $stable(vld_ff), "valid bits moved")
   `TILT_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

>>> design/tilt_lane.sv
module tilt_lane import tilt_pkg::*; #(
   parameter int SAMPLE_BITS = 8,
   parameter int ANGLE_FRAC_BITS = 4,
   parameter bit NUM_IS_ROOT = 1'b0
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          neg_in,
   input  logic [SAMPLE_BITS-1:0]        mag_in,
   input  logic [2*SAMPLE_BITS-1:0]      sumsq_in,
   output logic [8+ANGLE_FRAC_BITS-1:0]  angle_out
);

   localparam int SB = SAMPLE_BITS;
   localparam int NS = SB + WFRAC;
   localparam int NR = SB + WFRAC;
   localparam int RW = SB + WFRAC + 3;
   localparam int SW = 2 * SB;
   localparam int CW = SB + WFRAC + 3;
   localparam int ZW = WFRAC + 9;
   localparam int AB = 8 + ANGLE_FRAC_BITS;
   localparam logic [ZW-1:0] LIM = ZW'(90 << ANGLE_FRAC_BITS);
   localparam logic [ZW-1:0] HALF = ZW'(1) << (WFRAC - 1);

   logic [RW-1:0]  rem_ff  [NS];
   logic [NR-1:0]  root_ff [NS];
   logic [SW-1:0]  sq_ff   [NS];
   logic [SB-1:0]  mag_ff  [NS];
   tilt_flags_type flg_ff  [NS];

   logic signed [CW-1:0] cx_ff [ITERS];
   logic signed [CW-1:0] cy_ff [ITERS];
   logic signed [ZW-1:0] cz_ff [ITERS];
   tilt_flags_type       cf_ff [ITERS];

   logic [AB-1:0]  angle_ff;

   tilt_flags_type entry_flags;

   always_comb begin
      entry_flags.neg = neg_in;
      if (NUM_IS_ROOT) begin
         entry_flags.zero_num = (sumsq_in == '0);
         entry_flags.zero_den = (mag_in == '0);
      end else begin
         entry_flags.zero_num = (mag_in == '0);
         entry_flags.zero_den = (sumsq_in == '0);
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [RW-1:0]  rem_p;
      logic [NR-1:0]  root_p;
      logic [SW-1:0]  sq_p;
      logic [SB-1:0]  mag_p;
      tilt_flags_type fl_p;
      logic [1:0]     bits;
      logic [RW-1:0]  rem_sh;
      logic [RW-1:0]  trial;
      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign sq_p   = sumsq_in;
         assign mag_p  = mag_in;
         assign fl_p   = entry_flags;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign sq_p   = sq_ff[k-1];
         assign mag_p  = mag_ff[k-1];
         assign fl_p   = flg_ff[k-1];
      end
      if (SB - 1 - k >= 0) begin : g_bits
         assign bits = sq_p[2*(SB-1-k)+1 -: 2];
      end else begin : g_zero
         assign bits = 2'b00;
      end
      assign rem_sh = {rem_p[RW-3:0], bits};
      assign trial  = {1'b0, root_p, 2'b01};
      always_ff @(posedge clock) begin
         if (enable) begin
            if (rem_sh >= trial) begin
               rem_ff[k]  <= rem_sh - trial;
               root_ff[k] <= {root_p[NR-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= rem_sh;
               root_ff[k] <= {root_p[NR-2:0], 1'b0};
            end
            sq_ff[k]  <= sq_p;
            mag_ff[k] <= mag_p;
            flg_ff[k] <= fl_p;
         end
      end
   end

   logic signed [CW-1:0] root_ext;
   logic signed [CW-1:0] mag_ext;

   assign root_ext = signed'({3'b000, root_ff[NS-1]});
   assign mag_ext  = signed'({3'b000, mag_ff[NS-1], {WFRAC{1'b0}}});

   for (genvar i = 0; i < ITERS; i++) begin : g_cordic
      logic signed [CW-1:0] x_p;
      logic signed [CW-1:0] y_p;
      logic signed [ZW-1:0] z_p;
      tilt_flags_type       f_p;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [ZW-1:0] step;
      if (i == 0) begin : g_first
         assign x_p = NUM_IS_ROOT ? mag_ext : root_ext;
         assign y_p = NUM_IS_ROOT ? root_ext : mag_ext;
         assign z_p = '0;
         assign f_p = flg_ff[NS-1];
      end else begin : g_next
         assign x_p = cx_ff[i-1];
         assign y_p = cy_ff[i-1];
         assign z_p = cz_ff[i-1];
         assign f_p = cf_ff[i-1];
      end
      assign xs   = x_p >>> i;
      assign ys   = y_p >>> i;
      assign step = signed'(STEP_DEG[i][ZW-1:0]);
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!y_p[CW-1]) begin
               cx_ff[i] <= x_p + ys;
               cy_ff[i] <= y_p - xs;
               cz_ff[i] <= z_p + step;
            end else begin
               cx_ff[i] <= x_p - ys;
               cy_ff[i] <= y_p + xs;
               cz_ff[i] <= z_p - step;
            end
            cf_ff[i] <= f_p;
         end
      end
   end

   logic [ZW-1:0] z_clamp;
   logic [ZW-1:0] z_round;
   logic [ZW-1:0] z_mag;
   logic [AB-1:0] mag_sel;
   tilt_flags_type f_last;

   assign f_last = cf_ff[ITERS-1];

   always_comb begin
      z_clamp = cz_ff[ITERS-1][ZW-1] ? '0 : cz_ff[ITERS-1];
      z_round = (z_clamp + HALF) >> (WFRAC - ANGLE_FRAC_BITS);
      z_mag   = (z_round > LIM) ? LIM : z_round;
      if (f_last.zero_num) mag_sel = '0;
      else if (f_last.zero_den) mag_sel = LIM[AB-1:0];
      else mag_sel = z_mag[AB-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= f_last.neg ? (AB'(0) - mag_sel) : mag_sel;
      end
   end

   assign angle_out = angle_ff;

endmodule

>>> bench/tilt_angle_checker.sv
`timescale 1ns / 1ps

module tilt_angle_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [11:0] angle_z;
      logic [11:0] angle_y;
      logic [11:0] angle_x;
   } angles_type;

   localparam int FRAC_W = 40;
   localparam int N_STEPS = 48;
   localparam longint LIMIT_90 = 90 * 16;

   longint unsigned step_deg_tab [N_STEPS];
   angles_type      expected_angles [$];

   function automatic longint unsigned arctan_series(longint unsigned p, longint unsigned div,
                                                     int unsigned sh);
      longint unsigned sum, m, t;
      sum = 0;
      m = 0;
      while (p != 0) begin
         t = p / (2 * m + 1);
         if (m[0]) sum = sum - t;
         else sum = sum + t;
         if (div != 0) p = p / div;
         else p = (sh < 64) ? (p >> sh) : 64'd0;
         m = m + 1;
      end
      return sum;
   endfunction

   function automatic longint unsigned rad_to_deg(longint unsigned a, longint unsigned pi_v);
      longint unsigned num, q, r;
      num = a * 64'd180;
      q = num / pi_v;
      r = num % pi_v;
      for (int k = 0; k < FRAC_W; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= pi_v) begin
            r = r - pi_v;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic longint unsigned root_frac(longint unsigned s);
      longint unsigned root, rem, bits, trial;
      root = 0;
      rem = 0;
      for (int p = 15; p >= -FRAC_W; p--) begin
         bits = (p >= 0) ? ((s >> (2 * p)) & 64'd3) : 64'd0;
         rem = (rem << 2) | bits;
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint arctan_mag(longint unsigned den, longint unsigned num);
      longint x, y, z, nx, m;
      longint unsigned zr;
      if (num == 0) return 0;
      if (den == 0) return LIMIT_90;
      x = den;
      y = num;
      z = 0;
      for (int i = 0; i < N_STEPS; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'(step_deg_tab[i]);
         end else begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'(step_deg_tab[i]);
         end
         x = nx;
      end
      if (z < 0) z = 0;
      zr = (longint'(z) + (64'd1 << (FRAC_W - 1))) >> (FRAC_W - 4);
      m = zr;
      return (m > LIMIT_90) ? LIMIT_90 : m;
   endfunction

   function automatic logic [11:0] signed_angle(longint mag, logic neg);
      longint unsigned u;
      u = mag;
      if (neg) u = 64'd0 - u;
      return u[11:0];
   endfunction

   function automatic angles_type predict_angles(logic [23:0] d);
      longint x, y, z;
      longint unsigned ax, ay, az;
      angles_type a;
      x = longint'($signed(d[7:0]));
      y = longint'($signed(d[15:8]));
      z = longint'($signed(d[23:16]));
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      a.angle_x = signed_angle(arctan_mag(root_frac(ay * ay + az * az), ax << FRAC_W), x < 0);
      a.angle_y = signed_angle(arctan_mag(root_frac(ax * ax + az * az), ay << FRAC_W), y < 0);
      a.angle_z = signed_angle(arctan_mag(az << FRAC_W, root_frac(ax * ax + ay * ay)), z < 0);
      return a;
   endfunction

   initial begin
      longint unsigned one, pi_v;
      one = 64'd1 << 56;
      pi_v = 64'd16 * arctan_series(one / 64'd5, 64'd25, 0)
           - 64'd4 * arctan_series(one / 64'd239, 64'd57121, 0);
      step_deg_tab[0] = 64'd45 << FRAC_W;
      for (int i = 1; i < N_STEPS; i++)
         step_deg_tab[i] = rad_to_deg(arctan_series(one >> i, 0, 2 * i), pi_v);
   end

   always @(posedge clock) begin
      angles_type e, got;
      if (reset) begin
         expected_angles.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[35:0];
            if (expected_angles.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               fail_count++;
            end else begin
               e = expected_angles.pop_front();
               if (got.angle_x !== e.angle_x) begin
                  $error("angle_x expected %0d actual %0d",
                         $signed(e.angle_x), $signed(got.angle_x));
                  fail_count++;
               end
               if (got.angle_y !== e.angle_y) begin
                  $error("angle_y expected %0d actual %0d",
                         $signed(e.angle_y), $signed(got.angle_y));
                  fail_count++;
               end
               if (got.angle_z !== e.angle_z) begin
                  $error("angle_z expected %0d actual %0d",
                         $signed(e.angle_z), $signed(got.angle_z));
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_angles.push_back(predict_angles(req_tdata));
      end
      pending <= expected_angles.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   int          fail_count;
   int          pending;
   int          idle_cycles;
   bit          hold_rsp;
   bit          no_gaps;

   accel_tilt_angles_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   tilt_angle_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_sample(logic [7:0] x, logic [7:0] y, logic [7:0] z);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_axis(bit narrow);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'h80;
      if (r == 2) return 8'h7f;
      if (narrow) return 8'($urandom_range(0, 6) - 3);
      return 8'($urandom);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 20000) begin
            $display("FAIL accel_tilt_angles_top");
            $finish;
         end
      end
   end

   initial begin
      int g;
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         g = pick_gap();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      logic [7:0] edge_vals [5];
      bit narrow;
      edge_vals = '{8'h80, 8'hff, 8'h00, 8'h01, 8'h7f};
      hold_rsp = 1'b0;
      no_gaps = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_sample(8'h00, 8'h00, 8'h00);
      send_sample(8'h00, 8'h00, 8'h05);
      send_sample(8'h00, 8'h00, 8'hfb);
      send_sample(8'h00, 8'h00, 8'h80);
      send_sample(8'h07, 8'h00, 8'h00);
      send_sample(8'hf9, 8'h00, 8'h00);
      send_sample(8'h00, 8'h80, 8'h00);
      send_sample(8'h00, 8'h7f, 8'h00);
      send_sample(8'h01, 8'h01, 8'h01);
      send_sample(8'h80, 8'h80, 8'h80);
      send_sample(8'h7f, 8'h7f, 8'h7f);
      send_sample(8'h80, 8'h7f, 8'h01);
      send_sample(8'h7f, 8'h01, 8'hff);
      send_sample(8'h01, 8'h80, 8'hff);
      for (int i = 0; i < 10; i++)
         send_sample(edge_vals[$urandom_range(0, 4)], edge_vals[$urandom_range(0, 4)],
                     edge_vals[$urandom_range(0, 4)]);
      for (int n = 0; n < 1900; n++) begin
         if (n % 250 == 0) no_gaps = ~no_gaps;
         if (n == 700) hold_rsp = 1'b1;
         if (n == 1300) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         narrow = ($urandom_range(0, 3) == 0);
         send_sample(rand_axis(narrow), rand_axis(narrow), rand_axis(narrow));
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS accel_tilt_angles_top");
      end else begin
         $display("FAIL accel_tilt_angles_top");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/tilt_pkg.sv
design/tilt_lane.sv
design/accel_tilt_angles_top.sv
bench/tilt_angle_checker.sv
bench/testbench.sv
